[design/cbcs_pkg.sv]
package cbcs_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int COL_W = 10;
  localparam int LVL_W = 8;
  localparam int SUM_W = 28;
  localparam int CNT_W = 19;
  localparam int CFG_W = 10;
  localparam int IDX_W = 2;

  localparam longint PIXELS_PER_FRAME = longint'(FRAME_WIDTH) * longint'(FRAME_HEIGHT);
  localparam longint CNT_FIELD_MAX    = (longint'(1) << CNT_W) - 1;
  localparam longint COUNT_LIMIT_L    =
    (PIXELS_PER_FRAME > CNT_FIELD_MAX) ? CNT_FIELD_MAX : PIXELS_PER_FRAME;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(COUNT_LIMIT_L);
  localparam logic [COL_W:0]   FRAME_WIDTH_V = (COL_W + 1)'(FRAME_WIDTH);

  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [LVL_W-1:0] RED_THRESHOLD_RST  = LVL_W'(130);
  localparam logic [LVL_W-1:0] BLUE_THRESHOLD_RST = LVL_W'(50);
  localparam logic [COL_W-1:0] CENTER_COLUMN_RST  = COL_W'(320);
  localparam logic [COL_W-1:0] DEAD_BAND_RST      = COL_W'(30);

  typedef enum logic [IDX_W-1:0] {
    REG_RED_THRESHOLD  = 2'd0,
    REG_BLUE_THRESHOLD = 2'd1,
    REG_CENTER_COLUMN  = 2'd2,
    REG_DEAD_BAND      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    STEER_RIGHT  = 2'd0,
    STEER_LEFT   = 2'd1,
    STEER_CENTER = 2'd2
  } steer_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[design/color_blob_centroid_steer.sv]
// Color blob centroid tracker with steering output. Pixels arrive as items with
// their column and red and blue levels; a pixel whose red level is strictly above
// the red threshold, whose blue level is strictly below the blue threshold and
// whose column lies inside the frame is a target, and it adds its column to a
// running sum and raises a target count. The item that carries frame_end is
// accounted like any other and then closes the frame: one result item follows,
// holding the truncated mean column of the targets (0 when none matched), the
// target count and a steering code (0 target right of the dead band, 1 target
// left, 2 centered). A frame streams at one pixel per clock. After the frame_end
// pixel the block is not ready while a restoring divider that shares one 20-bit
// subtract and compare runs 28 steps, one quotient bit per cycle, and then while
// ST_DONE loads the result register. If the previous result has not been taken
// yet, the block waits in ST_DONE until the output register is free. Configuration
// writes take effect at once and are meant to happen only while the block is idle.
module color_blob_centroid_steer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cbcs_pkg::IDX_W-1:0] cfg_index,
  input  logic [cbcs_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cbcs_pkg::COL_W-1:0] in_pixel_column,
  input  logic [cbcs_pkg::LVL_W-1:0] in_red_level,
  input  logic [cbcs_pkg::LVL_W-1:0] in_blue_level,
  input  logic                      in_frame_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cbcs_pkg::COL_W-1:0] out_centroid_column,
  output logic [cbcs_pkg::CNT_W-1:0] out_target_count,
  output logic [1:0]                out_steer_action
);
  import cbcs_pkg::*;

  // Configuration registers.
  logic [LVL_W-1:0] red_threshold_r;
  logic [LVL_W-1:0] blue_threshold_r;
  logic [COL_W-1:0] center_column_r;
  logic [COL_W-1:0] dead_band_r;

  // Frame accumulators.
  logic [SUM_W-1:0] column_sum_r, column_sum_nxt;
  logic [CNT_W-1:0] match_count_r, match_count_nxt;

  // Divider state: quot_r starts as the dividend and fills with quotient bits.
  state_t           state_r, state_nxt;
  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] divisor_r, divisor_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [COL_W-1:0] out_centroid_r, out_centroid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  steer_t           out_steer_r, out_steer_nxt;

  logic             in_fire;
  logic             is_target;
  logic [SUM_W:0]   sum_plus;
  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] cnt_acc;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_diff;
  logic [COL_W-1:0] centroid;
  logic [COL_W:0]   upper_edge;
  logic [COL_W:0]   lower_test;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_centroid_column = out_centroid_r;
  assign out_target_count    = out_count_r;
  assign out_steer_action    = out_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_threshold_r  <= RED_THRESHOLD_RST;
      blue_threshold_r <= BLUE_THRESHOLD_RST;
      center_column_r  <= CENTER_COLUMN_RST;
      dead_band_r      <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_RED_THRESHOLD:  red_threshold_r  <= cfg_data[LVL_W-1:0];
        REG_BLUE_THRESHOLD: blue_threshold_r <= cfg_data[LVL_W-1:0];
        REG_CENTER_COLUMN:  center_column_r  <= cfg_data[COL_W-1:0];
        REG_DEAD_BAND:      dead_band_r      <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel classification and the saturating accumulate for this pixel.
  always_comb begin
    is_target = ({1'b0, in_pixel_column} < FRAME_WIDTH_V) &&
                (in_red_level > red_threshold_r) &&
                (in_blue_level < blue_threshold_r);
    sum_plus = {1'b0, column_sum_r} + (SUM_W + 1)'(in_pixel_column);
    sum_acc  = column_sum_r;
    cnt_acc  = match_count_r;
    if (is_target && (match_count_r < COUNT_LIMIT)) begin
      cnt_acc = match_count_r + CNT_W'(1);
      sum_acc = sum_plus[SUM_W] ? {SUM_W{1'b1}} : sum_plus[SUM_W-1:0];
    end
  end

  // Shared divider step: one compare and subtract per cycle.
  always_comb begin
    trial      = {rem_r, quot_r[SUM_W-1]};
    trial_diff = trial - {1'b0, divisor_r};
  end

  // Centroid clamp and steering decision on the finished quotient.
  always_comb begin
    if (divisor_r == '0) begin
      centroid = '0;
    end else if (quot_r[SUM_W-1:COL_W] != '0) begin
      centroid = {COL_W{1'b1}};
    end else begin
      centroid = quot_r[COL_W-1:0];
    end
    // centroid - center > dead_band, and centroid - center < -dead_band.
    upper_edge = {1'b0, center_column_r} + {1'b0, dead_band_r};
    lower_test = {1'b0, centroid} + {1'b0, dead_band_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      column_sum_r  <= '0;
      match_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      column_sum_r  <= column_sum_nxt;
      match_count_r <= match_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r         <= quot_nxt;
    rem_r          <= rem_nxt;
    divisor_r      <= divisor_nxt;
    step_r         <= step_nxt;
    out_centroid_r <= out_centroid_nxt;
    out_count_r    <= out_count_nxt;
    out_steer_r    <= out_steer_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    column_sum_nxt   = column_sum_r;
    match_count_nxt  = match_count_r;
    quot_nxt         = quot_r;
    rem_nxt          = rem_r;
    divisor_nxt      = divisor_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r;
    out_centroid_nxt = out_centroid_r;
    out_count_nxt    = out_count_r;
    out_steer_nxt    = out_steer_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_frame_end) begin
            quot_nxt        = sum_acc;
            rem_nxt         = '0;
            divisor_nxt     = cnt_acc;
            step_nxt        = STEP_W'(DIV_STEPS - 1);
            column_sum_nxt  = '0;
            match_count_nxt = '0;
            state_nxt       = ST_DIV;
          end else begin
            column_sum_nxt  = sum_acc;
            match_count_nxt = cnt_acc;
          end
        end
      end
      ST_DIV: begin
        if (!trial_diff[CNT_W]) begin
          rem_nxt  = trial_diff[CNT_W-1:0];
          quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[CNT_W-1:0];
          quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_centroid_nxt = centroid;
          out_count_nxt    = divisor_r;
          priority if ({1'b0, centroid} > upper_edge) begin
            out_steer_nxt = STEER_RIGHT;
          end else if (lower_test < {1'b0, center_column_r}) begin
            out_steer_nxt = STEER_LEFT;
          end else begin
            out_steer_nxt = STEER_CENTER;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The divider always ends after its last step.
  a_div_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> (state_r == ST_DONE))
    else $error("divider did not finish after its last step");

  // A closed frame leaves the accumulators cleared.
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_frame_end) |=> (column_sum_r == '0 && match_count_r == '0))
    else $error("accumulators not cleared after frame end");

  // The target count never passes its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    match_count_r <= COUNT_LIMIT)
    else $error("target count above limit");

  // An empty frame reports centroid zero.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == '0) |-> (out_centroid_r == '0))
    else $error("empty frame with nonzero centroid");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_count_r)))
    else $error("pending result overwritten");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cbcs_pkg::*;

  // A pixel as it travels on the input channel.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] blue;
    logic             last;
  } pixel_t;

  // What the block reports when a frame closes.
  typedef struct packed {
    logic [COL_W-1:0] centroid;
    logic [CNT_W-1:0] count;
    steer_t           steer;
  } blob_report_t;

  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_WAIT  = 40;
  localparam longint SUM_CEIL    = (longint'(1) << SUM_W) - 1;
  localparam longint HIT_CEIL    = (longint'(1) << CNT_W) - 1;
  localparam longint HIT_LIMIT   =
    (longint'(FRAME_WIDTH) * FRAME_HEIGHT > HIT_CEIL) ? HIT_CEIL :
    longint'(FRAME_WIDTH) * FRAME_HEIGHT;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             cfg_we          = 1'b0;
  logic [IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0] cfg_data        = '0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic [COL_W-1:0] in_pixel_column = '0;
  logic [LVL_W-1:0] in_red_level    = '0;
  logic [LVL_W-1:0] in_blue_level   = '0;
  logic             in_frame_end    = 1'b0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [COL_W-1:0] out_centroid_column;
  logic [CNT_W-1:0] out_target_count;
  logic [1:0]       out_steer_action;

  color_blob_centroid_steer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_column     (in_pixel_column),
    .in_red_level        (in_red_level),
    .in_blue_level       (in_blue_level),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_centroid_column (out_centroid_column),
    .out_target_count    (out_target_count),
    .out_steer_action    (out_steer_action)
  );

  always #1 clk = ~clk;

  // Our own copy of the configuration registers, kept in step with every write.
  logic [LVL_W-1:0] red_floor;
  logic [LVL_W-1:0] blue_ceiling;
  logic [COL_W-1:0] center_col;
  logic [COL_W-1:0] dead_zone;

  // Running blob accumulation of the frame in progress.
  longint column_total = 0;
  longint frame_hits   = 0;

  pixel_t       pixel_fifo[$];
  blob_report_t frame_reports[$];

  int  pixels_queued   = 0;
  int  pixels_accepted = 0;
  int  frames_closed   = 0;
  int  reports_seen    = 0;
  int  fault_count     = 0;
  int  settings_used   = 0;
  bit  hit_saturated   = 1'b0;

  // Idle switches, set per phase by the stimulus process.
  bit  sender_idles    = 1'b0;
  bit  receiver_idles  = 1'b0;

  // The stimulus process bumps this token to ask the receiver for a long hold-off.
  int  hold_token      = 0;
  int  hold_seen       = 0;
  int  hold_left       = 0;
  int  recv_stall      = 0;
  int  send_gap        = 0;
  pixel_t px_on_bus;

  // Accounts one accepted pixel. When the pixel closes the frame, the report that
  // the block must produce is queued and the accumulation starts over.
  task automatic track_pixel(input pixel_t px);
    longint       sum_next;
    int           centroid;
    int           offset;
    blob_report_t rep;
    if (px.column < FRAME_WIDTH && px.red > red_floor && px.blue < blue_ceiling) begin
      if (frame_hits < HIT_LIMIT) begin
        frame_hits = frame_hits + 1;
        sum_next = column_total + px.column;
        column_total = (sum_next > SUM_CEIL) ? SUM_CEIL : sum_next;
      end else begin
        hit_saturated = 1'b1;
      end
    end
    if (px.last) begin
      centroid = (frame_hits == 0) ? 0 : int'(column_total / frame_hits);
      if (centroid > (1 << COL_W) - 1) centroid = (1 << COL_W) - 1;
      // The steering decision compares the signed offset against the dead zone.
      offset = centroid - int'(center_col);
      if (offset > int'(dead_zone)) rep.steer = STEER_RIGHT;
      else if (offset < -int'(dead_zone)) rep.steer = STEER_LEFT;
      else rep.steer = STEER_CENTER;
      rep.centroid = COL_W'(centroid);
      rep.count    = CNT_W'(frame_hits);
      frame_reports.push_back(rep);
      frame_hits    = 0;
      column_total  = 0;
      frames_closed = frames_closed + 1;
    end
  endtask

  // Driver: presents pixels from the queue, holding each one until it is taken,
  // and optionally leaves a random idle gap after each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_pixel(px_on_bus);
        pixels_accepted = pixels_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pixel_fifo.size() != 0) begin
          px_on_bus = pixel_fifo.pop_front();
          in_valid        <= 1'b1;
          in_pixel_column <= px_on_bus.column;
          in_red_level    <= px_on_bus.red;
          in_blue_level   <= px_on_bus.blue;
          in_frame_end    <= px_on_bus.last;
          send_gap = sender_idles ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every report taken from the block against the oldest one
  // predicted, and drives out_ready with random stalls and the long hold-off.
  always @(posedge clk) begin
    blob_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        reports_seen = reports_seen + 1;
        if (frame_reports.size() == 0) begin
          fault_count = fault_count + 1;
          if (fault_count <= 10)
            $display("unexpected report: centroid %0d count %0d steer %0d",
                     out_centroid_column, out_target_count, out_steer_action);
        end else begin
          want = frame_reports.pop_front();
          if (out_centroid_column !== want.centroid || out_target_count !== want.count ||
              out_steer_action !== want.steer) begin
            fault_count = fault_count + 1;
            if (fault_count <= 10)
              $display("report %0d wrong: centroid %0d/%0d count %0d/%0d steer %0d/%0d %s",
                       reports_seen, want.centroid, out_centroid_column, want.count,
                       out_target_count, want.steer, out_steer_action,
                       "(expected/actual)");
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (out_valid && out_ready) begin
        recv_stall = receiver_idles ? $urandom_range(0, 3) : 0;
        out_ready <= (recv_stall == 0);
      end else if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= (recv_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer_pixel(input int col, input int red, input int blue, input bit last);
    pixel_t px;
    px.column = COL_W'(col);
    px.red    = LVL_W'(red);
    px.blue   = LVL_W'(blue);
    px.last   = last;
    pixel_fifo.push_back(px);
    pixels_queued = pixels_queued + 1;
  endtask

  // Register write; the block samples it at the last edge of the task.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_RED_THRESHOLD:  red_floor    = value[LVL_W-1:0];
      REG_BLUE_THRESHOLD: blue_ceiling = value[LVL_W-1:0];
      REG_CENTER_COLUMN:  center_col   = value;
      REG_DEAD_BAND:      dead_zone    = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int red, input int blue, input int center, input int band);
    write_reg(REG_RED_THRESHOLD, CFG_W'(red));
    write_reg(REG_BLUE_THRESHOLD, CFG_W'(blue));
    write_reg(REG_CENTER_COLUMN, CFG_W'(center));
    write_reg(REG_DEAD_BAND, CFG_W'(band));
    settings_used = settings_used + 1;
  endtask

  // Waits until every queued pixel is taken and every report has come back, then
  // lets the divider run out so that a following register write sees an idle block.
  task automatic settle_block();
    while (pixels_accepted != pixels_queued || frame_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic int clamp_column(input int col);
    if (col < 0) return 0;
    if (col > FRAME_WIDTH - 1) return FRAME_WIDTH - 1;
    return col;
  endfunction

  // Random pixels lean toward the thresholds and toward a chosen aim point, so that
  // frames carry real blobs while the comparison edges still get hit.
  task automatic queue_frames(input int n_pixels, input int max_len);
    int left;
    int len;
    int aim;
    int spread;
    int col;
    int red;
    int blue;
    int pick;
    left = n_pixels;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      if ($urandom_range(0, 1) == 1)
        aim = clamp_column(int'(center_col) + $urandom_range(0, 2 * dead_zone + 4) -
                           (int'(dead_zone) + 2));
      else
        aim = $urandom_range(0, FRAME_WIDTH - 1);
      spread = $urandom_range(0, 40);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) col = $urandom_range(FRAME_WIDTH, (1 << COL_W) - 1);
        else if (pick < 60) col = clamp_column(aim + $urandom_range(0, 2 * spread) - spread);
        else col = $urandom_range(0, FRAME_WIDTH - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55 && red_floor != 8'hFF) red = $urandom_range(red_floor + 1, 255);
        else if (pick < 65) red = red_floor;
        else red = $urandom_range(0, 255);
        pick = $urandom_range(0, 99);
        if (pick < 55 && blue_ceiling != 8'h00) blue = $urandom_range(0, blue_ceiling - 1);
        else if (pick < 65) blue = blue_ceiling;
        else blue = $urandom_range(0, 255);
        offer_pixel(col, red, blue, i == len - 1);
      end
      left = left - len;
    end
  endtask

  initial begin
    red_floor    = RED_THRESHOLD_RST;
    blue_ceiling = BLUE_THRESHOLD_RST;
    center_col   = CENTER_COLUMN_RST;
    dead_zone    = DEAD_BAND_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_used = 1;

    // Directed frames under the reset settings: red above 130, blue below 50,
    // center 320 with a dead zone of 30.
    offer_pixel(100, 0, 255, 1);      // empty frame, centroid 0 reads as left
    offer_pixel(639, 255, 0, 1);      // rightmost column alone
    offer_pixel(320, 130, 0, 0);      // red equal to threshold does not count
    offer_pixel(320, 131, 49, 0);     // just inside both thresholds
    offer_pixel(500, 200, 50, 0);     // blue equal to threshold does not count
    offer_pixel(640, 255, 0, 0);      // first column outside the frame
    offer_pixel(1023, 255, 0, 1);     // outside the frame, still closes it
    offer_pixel(350, 131, 49, 1);     // exactly on the right edge of the band
    offer_pixel(351, 131, 49, 1);     // one past it
    offer_pixel(290, 200, 10, 1);     // exactly on the left edge
    offer_pixel(289, 200, 10, 1);     // one past it
    offer_pixel(0, 255, 0, 0);
    offer_pixel(1, 255, 0, 0);
    offer_pixel(639, 255, 0, 1);      // mean 213.33 truncates
    offer_pixel(10, 255, 0, 0);
    offer_pixel(11, 255, 0, 1);       // mean 10.5 truncates
    settle_block();

    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    queue_frames(200, 16);
    settle_block();

    // Widest thresholds with center and band at zero, no idling on either side.
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    write_all(0, 255, 0, 0);
    queue_frames(120, 12);
    settle_block();

    // Nothing can match, the band covers everything.
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    write_all(255, 0, 1023, 1023);
    queue_frames(60, 8);
    settle_block();

    // Back pressure: the receiver holds off while short frames keep coming, so the
    // output register stays full and the block has to stall its input.
    write_all(100, 150, 320, 20);
    hold_token = hold_token + 1;
    queue_frames(150, 6);
    settle_block();

    // Fully random register values, upper data bits included.
    repeat (2) begin
      write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      queue_frames(120, 16);
      settle_block();
    end

    if (frame_reports.size() != 0) begin
      fault_count = fault_count + frame_reports.size();
      $display("%0d reports never arrived", frame_reports.size());
    end

    $display("Ran %0d pixels in %0d frames over %0d register settings (%0d reports seen).",
             pixels_accepted, frames_closed, settings_used, reports_seen);
    $display("Covered threshold edges, band edges, empty frames, back pressure, and %s",
             hit_saturated ? "a saturated target count." : "no count saturation.");
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net: a run that does not finish by this timeout is reported as failed.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
design/cbcs_pkg.sv
design/color_blob_centroid_steer.sv
sim/tb_top.sv
